FILE: sv/assert_macros.svh
// Assertion macros for the RTL that checks itself (the top level uses them).
// Depends on signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/wfu_pkg.sv
// Shared types, codes and constants of the frame unmasker.
// No dependencies; imported by every module of the block.
package wfu_pkg;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_REPLY   = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [1:0] STATUS_PROCESSED     = 2'd0;
   localparam logic [1:0] STATUS_CLOSE_HANDLED = 2'd1;
   localparam logic [1:0] STATUS_FRAME_ERROR   = 2'd2;
   localparam logic [1:0] STATUS_NOT_PROCESSED = 2'd3;

   localparam logic [3:0] OPCODE_TEXT  = 4'h1;
   localparam logic [3:0] OPCODE_CLOSE = 4'h8;

   localparam logic [6:0] MAX_PAYLOAD    = 7'd125;
   localparam logic [7:0] PAYLOAD_OFFSET = 8'd6;
   localparam logic [7:0] POSITION_MAX   = 8'd255;

   localparam logic [2:0] REPLY_LEN = 3'd4;
   localparam logic [7:0] CLOSE_REPLY_LAST = 8'hE9;

   typedef struct packed {
      logic       emit_payload;
      logic [7:0] payload_byte;
      logic       emit_status;
      logic [1:0] status;
      logic       close_reply;
   } plan_type;

   function automatic logic [7:0] close_reply_byte(input logic [1:0] idx);
      logic [7:0] result;
      case (idx)
         2'd0: result = 8'h88;
         2'd1: result = 8'h02;
         2'd2: result = 8'h03;
         default: result = CLOSE_REPLY_LAST;
      endcase
      return result;
   endfunction

endpackage

FILE: sv/wfu_frame_parser.sv
// Frame parser: header, length and mask tracking, payload unmasking and
// end-of-buffer status. Depends on wfu_pkg.
module wfu_frame_parser import wfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       link_ready,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_buffer,
   input  logic       plan_ready,
   output logic       plan_load,
   output plan_type   plan
);

   logic [7:0] position_ff, position_in;
   logic       frame_error_ff, frame_error_in;
   logic       is_close_ff, is_close_in;
   logic       mask_present_ff, mask_present_in;
   logic [6:0] payload_length_ff, payload_length_in;
   logic [7:0] mask_ff [4];
   logic [7:0] mask_in [4];

   logic       accept;
   logic [7:0] payload_index;
   logic [1:0] mask_sel;
   logic [8:0] buffer_len;
   logic [8:0] needed_len;
   logic [3:0] opcode;

   assign req_stall     = !plan_ready;
   assign accept        = req_valid && plan_ready;
   assign opcode        = req_data_byte[3:0];
   assign payload_index = position_ff - PAYLOAD_OFFSET;
   assign mask_sel      = position_ff[1:0] + 2'd2;
   assign buffer_len    = {1'b0, position_ff} + 9'd1;
   assign needed_len    = {2'b00, payload_length_ff} + {1'b0, PAYLOAD_OFFSET};

   always_comb begin
      plan.emit_payload = (position_ff >= PAYLOAD_OFFSET)
                       && (payload_index < {1'b0, payload_length_ff})
                       && !frame_error_ff && !is_close_ff
                       && (payload_length_ff < MAX_PAYLOAD);
      plan.payload_byte = req_data_byte ^ mask_ff[mask_sel];
      plan.emit_status  = req_end_of_buffer;
      plan.close_reply  = 1'b0;
      if (!link_ready || position_ff < PAYLOAD_OFFSET) begin
         plan.status = STATUS_NOT_PROCESSED;
      end else if (frame_error_ff) begin
         plan.status = STATUS_FRAME_ERROR;
      end else if (buffer_len < needed_len) begin
         plan.status = STATUS_NOT_PROCESSED;
      end else if (payload_length_ff >= MAX_PAYLOAD) begin
         plan.status = STATUS_FRAME_ERROR;
      end else if (is_close_ff) begin
         plan.status      = STATUS_CLOSE_HANDLED;
         plan.close_reply = req_end_of_buffer;
      end else begin
         plan.status = STATUS_PROCESSED;
      end
   end

   assign plan_load = accept && (plan.emit_payload || plan.emit_status);

   always_comb begin
      position_in       = position_ff;
      frame_error_in    = frame_error_ff;
      is_close_in       = is_close_ff;
      mask_present_in   = mask_present_ff;
      payload_length_in = payload_length_ff;
      mask_in           = mask_ff;
      if (accept) begin
         if (position_ff == 8'd0) begin
            frame_error_in = !req_data_byte[7]
                          || (opcode != OPCODE_TEXT && opcode != OPCODE_CLOSE);
            is_close_in    = (opcode == OPCODE_CLOSE);
         end else if (position_ff == 8'd1) begin
            mask_present_in   = req_data_byte[7];
            payload_length_in = req_data_byte[6:0];
         end else if (position_ff < PAYLOAD_OFFSET) begin
            mask_in[mask_sel] = mask_present_ff ? req_data_byte : 8'd0;
         end
         if (position_ff != POSITION_MAX) begin
            position_in = position_ff + 8'd1;
         end
         if (req_end_of_buffer) begin
            position_in       = 8'd0;
            frame_error_in    = 1'b0;
            is_close_in       = 1'b0;
            mask_present_in   = 1'b0;
            payload_length_in = 7'd0;
            mask_in           = '{default: 8'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= 8'd0;
         frame_error_ff    <= 1'b0;
         is_close_ff       <= 1'b0;
         mask_present_ff   <= 1'b0;
         payload_length_ff <= 7'd0;
         mask_ff           <= '{default: 8'd0};
      end else begin
         position_ff       <= position_in;
         frame_error_ff    <= frame_error_in;
         is_close_ff       <= is_close_in;
         mask_present_ff   <= mask_present_in;
         payload_length_ff <= payload_length_in;
         mask_ff           <= mask_in;
      end
   end

endmodule

FILE: sv/wfu_result_sequencer.sv
// Result sequencer: holds one item's plan and walks its results into the
// output register, one per cycle while rsp_stall is low. Depends on wfu_pkg.
module wfu_result_sequencer import wfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       plan_load,
   input  plan_type   plan,
   output logic       plan_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_data,
   output logic [1:0] rsp_frame_status,
   output logic       rsp_last_of_run
);

   plan_type   plan_ff, plan_in;
   logic       plan_valid_ff, plan_valid_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic [2:0] count;
   logic       load_out;
   logic       final_step;

   assign count = {2'b00, plan_ff.emit_payload} + {2'b00, plan_ff.emit_status}
                + (plan_ff.close_reply ? REPLY_LEN : 3'd0);
   assign load_out   = plan_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_step = (step_ff == count - 3'd1);
   assign plan_ready = !plan_valid_ff || (load_out && final_step);

   always_comb begin
      plan_in       = plan_ff;
      plan_valid_in = plan_valid_ff;
      step_in       = step_ff;
      if (plan_load) begin
         plan_in       = plan;
         plan_valid_in = 1'b1;
         step_in       = 3'd0;
      end else if (load_out && final_step) begin
         plan_valid_in = 1'b0;
         step_in       = 3'd0;
      end else if (load_out) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         last_in      = final_step;
         if (plan_ff.emit_payload && step_ff == 3'd0) begin
            kind_in   = KIND_PAYLOAD;
            data_in   = plan_ff.payload_byte;
            status_in = STATUS_PROCESSED;
         end else if (plan_ff.close_reply && step_ff < REPLY_LEN) begin
            kind_in   = KIND_REPLY;
            data_in   = close_reply_byte(step_ff[1:0]);
            status_in = STATUS_PROCESSED;
         end else begin
            kind_in   = KIND_STATUS;
            data_in   = 8'd0;
            status_in = plan_ff.status;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_valid_ff <= 1'b0;
         step_ff       <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         plan_valid_ff <= plan_valid_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff   <= plan_in;
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = kind_ff;
   assign rsp_out_data     = data_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

FILE: sv/websocket_frame_unmasker.sv
// Top level of the frame unmasker: link-ready register, parser, sequencer.
// Depends on wfu_pkg, wfu_frame_parser, wfu_result_sequencer, assert_macros.svh.
//
//   channel  handshake              payload
//   req      req_valid/req_stall    req_data_byte, req_end_of_buffer
//   rsp      rsp_valid/rsp_stall    rsp_out_kind, rsp_out_data, rsp_frame_status,
//                                   rsp_last_of_run
//   csr      csr_write_enable       csr_write_data (link_ready)
//
// One byte per cycle when each byte gives at most one result and rsp_stall is
// low; a close frame's final byte gives five results (reply bytes and status).
// The first result of a byte goes through the plan register, then the output
// register, onto rsp. The plan and output registers set the rate; header bytes
// give no result and skip the plan register. Reset is synchronous and clears
// all control and frame state; rsp_stall backs up into req_stall.
`include "assert_macros.svh"

module websocket_frame_unmasker import wfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_data,
   output logic [1:0] rsp_frame_status,
   output logic       rsp_last_of_run
);

   logic     link_ready_ff, link_ready_in;
   logic     plan_ready;
   logic     plan_load;
   plan_type plan;

   assign link_ready_in = csr_write_enable ? csr_write_data : link_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
      end else begin
         link_ready_ff <= link_ready_in;
      end
   end

   wfu_frame_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .link_ready        (link_ready_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .plan_ready        (plan_ready),
      .plan_load         (plan_load),
      .plan              (plan)
   );

   wfu_result_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .plan_load        (plan_load),
      .plan             (plan),
      .plan_ready       (plan_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_data     (rsp_out_data),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   `ASSERT_IMPL(a_status_ends_run, rsp_valid && rsp_out_kind == KIND_STATUS, rsp_last_of_run)
   `ASSERT_IMPL(a_status_no_data, rsp_valid && rsp_out_kind == KIND_STATUS, rsp_out_data == 8'd0)
   `ASSERT_IMPL(a_data_zero_status, rsp_valid && rsp_out_kind != KIND_STATUS, rsp_frame_status == STATUS_PROCESSED)
   `ASSERT_NEXT(a_reply_then_close, rsp_valid && !rsp_stall && rsp_out_kind == KIND_REPLY && rsp_out_data == CLOSE_REPLY_LAST, rsp_valid && rsp_out_kind == KIND_STATUS && rsp_frame_status == STATUS_CLOSE_HANDLED)

endmodule

FILE: dv/websocket_frame_unmasker_tb.sv
// Testbench for websocket_frame_unmasker: drives received buffers byte by byte and checks
// every unmasked byte, close reply byte and status against an in-bench frame predictor.
// Depends on wfu_pkg and the websocket_frame_unmasker RTL.
module websocket_frame_unmasker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wfu_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_BYTES   = 12;

   localparam logic [3:0] OPCODE_BINARY = 4'h2;
   localparam logic [7:0] FIN_BIT       = 8'h80;
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [7:0] HDR_TEXT      = FIN_BIT | {4'h0, OPCODE_TEXT};
   localparam logic [7:0] HDR_CLOSE     = FIN_BIT | {4'h0, OPCODE_CLOSE};
   localparam logic [7:0] HDR_BINARY    = FIN_BIT | {4'h0, OPCODE_BINARY};
   localparam logic [7:0] CLOSE_BYTES [4] = '{8'h88, 8'h02, 8'h03, 8'hE9};

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_mode_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } frame_out_type;

   typedef logic [7:0] byte_q_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_data;
   logic [1:0] rsp_frame_status;
   logic       rsp_last_of_run;

   websocket_frame_unmasker dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_data     (rsp_out_data),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame predictor state
   logic       link_up = 1'b0;
   logic [7:0] rx_pos = 8'd0;
   logic       rx_bad_header = 1'b0;
   logic       rx_close = 1'b0;
   logic       rx_masked = 1'b0;
   logic [6:0] rx_len = 7'd0;
   logic [7:0] rx_key [4] = '{default: 8'h00};

   frame_out_type frame_output_q[$];
   int            errors = 0;
   int            byte_total = 0;
   int            buffer_total = 0;
   int            status_seen [4] = '{default: 0};
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            hold_requests = 0;
   int            hold_seen = 0;
   int            hold_left = 0;
   int            cycle_count = 0;

   task automatic predict_unmask(input logic [7:0] b, input logic eob);
      frame_out_type outs[$];
      int            idx;
      int            buf_len;
      logic [1:0]    status;
      idx = int'(rx_pos) - int'(PAYLOAD_OFFSET);
      if (rx_pos == 8'd0) begin
         rx_bad_header = !b[7] || (b[3:0] != OPCODE_TEXT && b[3:0] != OPCODE_CLOSE);
         rx_close = (b[3:0] == OPCODE_CLOSE);
      end else if (rx_pos == 8'd1) begin
         rx_masked = b[7];
         rx_len = b[6:0];
      end else if (rx_pos < PAYLOAD_OFFSET) begin
         rx_key[rx_pos[1:0] - 2'd2] = rx_masked ? b : 8'h00;
      end else if (idx < int'(rx_len) && !rx_bad_header && !rx_close
                   && rx_len < MAX_PAYLOAD) begin
         outs.push_back('{KIND_PAYLOAD, b ^ rx_key[idx % 4], STATUS_PROCESSED, 1'b0});
      end
      buf_len = int'(rx_pos) + 1;
      if (rx_pos != POSITION_MAX) rx_pos++;
      if (eob) begin
         if (!link_up || buf_len <= int'(PAYLOAD_OFFSET)) status = STATUS_NOT_PROCESSED;
         else if (rx_bad_header) status = STATUS_FRAME_ERROR;
         else if (buf_len < int'(rx_len) + int'(PAYLOAD_OFFSET)) status = STATUS_NOT_PROCESSED;
         else if (rx_len >= MAX_PAYLOAD) status = STATUS_FRAME_ERROR;
         else if (rx_close) begin
            foreach (CLOSE_BYTES[k])
               outs.push_back('{KIND_REPLY, CLOSE_BYTES[k], STATUS_PROCESSED, 1'b0});
            status = STATUS_CLOSE_HANDLED;
         end else status = STATUS_PROCESSED;
         outs.push_back('{KIND_STATUS, 8'h00, status, 1'b0});
         rx_pos = 8'd0;
         rx_bad_header = 1'b0;
         rx_close = 1'b0;
         rx_masked = 1'b0;
         rx_len = 7'd0;
         rx_key = '{default: 8'h00};
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) frame_output_q.push_back(outs[i]);
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         byte_total++;
         if (req_end_of_buffer) buffer_total++;
         predict_unmask(req_data_byte, req_end_of_buffer);
      end
   end

   always @(posedge clock) begin
      frame_out_type got;
      frame_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_kind, rsp_out_data, rsp_frame_status, rsp_last_of_run};
         if (frame_output_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer: expected none, actual %0d/%h/%0d/%0b",
                     $time, got.kind, got.data, got.status, got.last);
         end else begin
            want = frame_output_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data
                || got.status !== want.status || got.last !== want.last) begin
               errors++;
               $display("%0t: mismatch: expected %0d/%h/%0d/%0b, actual %0d/%h/%0d/%0b",
                        $time, want.kind, want.data, want.status, want.last,
                        got.kind, got.data, got.status, got.last);
            end
            if (want.kind == KIND_STATUS) status_seen[want.status]++;
         end
      end
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time, frame_output_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic set_idling(input idling_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 52 : (mode == IDLE_BOTH) ? 35 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 52 : (mode == IDLE_BOTH) ? 35 : 0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eob);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_buffer(input byte_q_type q);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_output_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_link_ready(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      link_up = value;
   endtask

   function automatic byte_q_type build_frame(input logic [7:0] hdr, input logic [7:0] len_byte,
                                              input logic [31:0] key, input int total,
                                              input int fill);
      byte_q_type q;
      int         k;
      for (k = 0; k < total; k++) begin
         if (k == 0) q.push_back(hdr);
         else if (k == 1) q.push_back(len_byte);
         else if (k < int'(PAYLOAD_OFFSET)) q.push_back(key[8 * (5 - k) +: 8]);
         else q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      end
      return q;
   endfunction

   task automatic test_link_down();
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd3, $urandom, 9, -1));
      send_buffer(build_frame(HDR_CLOSE, MASK_BIT, $urandom, 7, -1));
      send_buffer(build_frame(HDR_TEXT, 8'd0, 32'h0, 1, -1));
      drain();
   endtask

   task automatic test_directed_frames();
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd4, 32'hFFFF_FFFF, 10, 8'h00));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd4, 32'h0000_0000, 10, 8'hFF));
      send_buffer(build_frame(HDR_TEXT, 8'd4, 32'hA5C3_5A3C, 10, -1));
      send_buffer(build_frame(HDR_CLOSE, MASK_BIT, $urandom, 7, -1));
      send_buffer(build_frame(HDR_CLOSE, MASK_BIT | 8'd2, $urandom, 8, -1));
      send_buffer(build_frame(HDR_TEXT & ~FIN_BIT, MASK_BIT | 8'd2, $urandom, 8, -1));
      send_buffer(build_frame(HDR_BINARY, MASK_BIT | 8'd2, $urandom, 8, -1));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd10, $urandom, 10, -1));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT, $urandom, 6, -1));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT, $urandom, 1, -1));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd1, $urandom, 3, -1));
      send_buffer(build_frame(HDR_TEXT, MASK_BIT | 8'd125, $urandom, 8, -1));
      drain();
   endtask

   task automatic test_long_buffers();
      send_buffer(build_frame(HDR_TEXT, 8'd127, $urandom, 257, -1));
      drain();
   endtask

   task automatic send_random_buffer(output int total);
      logic [7:0] hdr;
      logic [6:0] plen;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         hdr = {1'b1, 3'($urandom), ($urandom_range(0, 3) == 0) ? OPCODE_CLOSE : OPCODE_TEXT};
      else
         hdr = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         plen  = 7'($urandom_range(17, 127));
         total = $urandom_range(1, 24);
      end else begin
         plen = 7'($urandom_range(0, 16));
         pick = $urandom_range(0, 9);
         if (pick < 7) total = int'(PAYLOAD_OFFSET) + int'(plen) + $urandom_range(0, 2);
         else total = $urandom_range(1, int'(PAYLOAD_OFFSET) + int'(plen));
      end
      send_buffer(build_frame(hdr, {1'($urandom), plen}, $urandom, total, -1));
   endtask

   task automatic test_random_frames();
      int phase;
      int sent;
      int total;
      for (phase = 0; phase < 4; phase++) begin
         write_link_ready(phase != 2);
         set_idling(idling_mode_type'(phase));
         sent = 0;
         while (sent < PHASE_BYTES) begin
            send_random_buffer(total);
            sent += total;
         end
         drain();
      end
   endtask

   task automatic test_backpressure();
      int n;
      write_link_ready(1'b1);
      set_idling(IDLE_NONE);
      hold_requests++;
      for (n = 0; n < 3; n++)
         send_buffer(build_frame(n == 2 ? HDR_CLOSE : HDR_TEXT, MASK_BIT | 8'd6,
                                 $urandom, 12, -1));
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_link_ready(1'b0);
      test_link_down();
      write_link_ready(1'b1);
      test_directed_frames();
      test_long_buffers();
      test_random_frames();
      test_backpressure();
      $display("Sent %0d buffers, %0d bytes: headers, masks, lengths, close and long frames,",
               buffer_total, byte_total);
      $display("link up and down, four idling patterns, receiver hold-off; statuses %0d/%0d/%0d/%0d",
               status_seen[STATUS_PROCESSED], status_seen[STATUS_CLOSE_HANDLED],
               status_seen[STATUS_FRAME_ERROR], status_seen[STATUS_NOT_PROCESSED]);
      if (errors == 0 && frame_output_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
